// File: src/cic_pkg.sv
// ---------------------------------------------------------------------------
// cic_pkg : conveyor interlock controller shared definitions
// Types, codes and constants shared by the controller modules.
// ---------------------------------------------------------------------------
package cic_pkg;

    localparam int COUNT_W     = 8;   // box counter width
    localparam int COUNT_OUT_W = 8;   // reported count width
    localparam int TIMER_W     = 16;
    localparam int CFG_W       = 16;
    localparam int CFG_IDX_W   = 1;
    localparam int ANGLE_W     = 8;

    localparam logic [CFG_IDX_W-1:0] CFG_METAL_HOLD = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_CLEAR_HOLD = 1'b1;

    localparam logic [TIMER_W-1:0] METAL_HOLD_RST = 16'd1000;
    localparam logic [TIMER_W-1:0] CLEAR_HOLD_RST = 16'd1500;

    localparam logic signed [ANGLE_W-1:0] ANGLE_CLEAR = 8'sd90;
    localparam logic signed [ANGLE_W-1:0] ANGLE_PUSH  = -8'sd90;

    localparam logic signed [COUNT_W-1:0] COUNT_MAX = {1'b0, {(COUNT_W-1){1'b1}}};
    localparam logic signed [COUNT_W-1:0] COUNT_MIN = {1'b1, {(COUNT_W-1){1'b0}}};

    typedef enum logic [3:0] {
        ST_IDLE        = 4'd0,
        ST_WAIT_GUARD  = 4'd1,
        ST_RESET_COUNT = 4'd2,
        ST_MOVE        = 4'd3,
        ST_CHECK       = 4'd4,
        ST_INVALID     = 4'd5,
        ST_METAL       = 4'd6,
        ST_EMERGENCY   = 4'd7,
        ST_CLEAR       = 4'd8
    } t_ctrl_state;

    typedef enum logic [1:0] {
        LED_OFF  = 2'd0,
        LED_ON   = 2'd1,
        LED_SLOW = 2'd2,
        LED_FAST = 2'd3
    } t_led;

    typedef struct packed {
        logic mode;            // 0 sensor sample, 1 time tick
        logic gate_start;
        logic gate_end;
        logic guard_left;
        logic guard_right;
        logic metal_sensed;
        logic emergency_pressed;
        logic reset_pressed;
    } t_item;

    typedef struct packed {
        t_ctrl_state                 state;
        logic signed [COUNT_W-1:0]   boxes;
        logic                        last_gate_start;
        logic                        last_gate_end;
        logic [TIMER_W-1:0]          hold_timer;
    } t_ctrl_regs;

    typedef struct packed {
        t_ctrl_state                   state_code;
        t_led                          led_mode;
        logic                          motor_on;
        logic signed [ANGLE_W-1:0]     servo_angle;
        logic signed [COUNT_OUT_W-1:0] count_now;
    } t_result;

endpackage

// File: src/cic_in_stage.sv
// ---------------------------------------------------------------------------
// cic_in_stage : input register
// Captures one input beat and holds it until the result stage has room.
// ---------------------------------------------------------------------------
module cic_in_stage import cic_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // gate_start, gate_end, guard_left,
                                       // guard_right, metal_sensed,
                                       // emergency_pressed, reset_pressed, 0
    input  logic       s_axis_tuser,   // mode
    input  logic       i_out_free,
    output logic       o_valid,
    output t_item      o_item
);

    logic  r_valid;
    t_item r_item;
    logic  w_take;

    assign s_axis_tready = !r_valid || i_out_free;
    assign w_take        = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_item.mode              <= s_axis_tuser;
            r_item.gate_start        <= s_axis_tdata[0];
            r_item.gate_end          <= s_axis_tdata[1];
            r_item.guard_left        <= s_axis_tdata[2];
            r_item.guard_right       <= s_axis_tdata[3];
            r_item.metal_sensed      <= s_axis_tdata[4];
            r_item.emergency_pressed <= s_axis_tdata[5];
            r_item.reset_pressed     <= s_axis_tdata[6];
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

// File: src/cic_step.sv
// ---------------------------------------------------------------------------
// cic_step : controller update logic
// Box counting, hold timers and the interlock state machine for one item.
// ---------------------------------------------------------------------------
module cic_step import cic_pkg::*; (
    input  t_item              i_item,
    input  t_ctrl_regs         i_regs,
    input  logic [TIMER_W-1:0] i_metal_hold,
    input  logic [TIMER_W-1:0] i_clear_hold,
    output t_ctrl_regs         o_regs,
    output t_result            o_result
);

    t_ctrl_state w_emit_state;

    // next state
    always_comb begin
        t_ctrl_state               st;
        logic [TIMER_W-1:0]        tmr;
        logic signed [COUNT_W-1:0] cnt;
        logic                      end_edge;
        logic                      both_guards;

        o_regs      = i_regs;
        st          = i_regs.state;
        tmr         = i_regs.hold_timer;
        cnt         = i_regs.boxes;
        end_edge    = i_item.gate_end && !i_regs.last_gate_end;
        both_guards = i_item.guard_left && i_item.guard_right;

        if (i_item.mode) begin
            if (st inside {ST_METAL, ST_CLEAR}) begin
                if (tmr != '0) begin
                    tmr = tmr - 1'b1;
                end
                if (tmr == '0) begin
                    st = (st == ST_METAL) ? ST_MOVE : ST_IDLE;
                end
            end
        end else begin
            if (i_item.gate_start && !i_regs.last_gate_start && cnt < COUNT_MAX) begin
                cnt = cnt + 1'b1;
            end
            if (end_edge && cnt > COUNT_MIN) begin
                cnt = cnt - 1'b1;
            end

            case (st)
                ST_IDLE: begin
                    if (i_item.emergency_pressed) st = ST_EMERGENCY;
                    else if (i_item.gate_start)   st = ST_WAIT_GUARD;
                end
                ST_WAIT_GUARD: begin
                    if (i_item.emergency_pressed) st = ST_EMERGENCY;
                    else if (both_guards)         st = ST_MOVE;
                end
                ST_MOVE: begin
                    if (i_item.emergency_pressed) begin
                        st = ST_EMERGENCY;
                    end else if (!both_guards) begin
                        st = ST_WAIT_GUARD;
                    end else if (i_item.metal_sensed) begin
                        st  = ST_METAL;
                        tmr = i_metal_hold;
                    end else if (end_edge) begin
                        st = ST_CHECK;
                    end
                end
                ST_CHECK: begin
                    if (cnt == '0) begin
                        st  = ST_CLEAR;
                        tmr = i_clear_hold;
                    end else if (cnt > 0) begin
                        st = ST_MOVE;
                    end else begin
                        st = ST_INVALID;
                    end
                end
                ST_INVALID, ST_EMERGENCY: begin
                    if (i_item.reset_pressed) st = ST_RESET_COUNT;
                end
                ST_METAL, ST_CLEAR: begin
                    st = i_regs.state;
                end
                default: begin
                    st = ST_IDLE;
                end
            endcase
            o_regs.last_gate_start = i_item.gate_start;
            o_regs.last_gate_end   = i_item.gate_end;
        end

        // reset count reports once, then drops to idle
        w_emit_state = st;
        if (st == ST_RESET_COUNT) begin
            cnt = '0;
            st  = ST_IDLE;
        end
        o_regs.state      = st;
        o_regs.boxes      = cnt;
        o_regs.hold_timer = tmr;
    end

    // actuator outputs
    always_comb begin
        o_result.state_code  = w_emit_state;
        o_result.led_mode    = LED_SLOW;
        o_result.motor_on    = 1'b0;
        o_result.servo_angle = ANGLE_CLEAR;
        o_result.count_now   = COUNT_OUT_W'(o_regs.boxes);
        case (w_emit_state)
            ST_IDLE: begin
                o_result.led_mode = LED_OFF;
            end
            ST_MOVE, ST_CHECK: begin
                o_result.led_mode = LED_ON;
                o_result.motor_on = 1'b1;
            end
            ST_METAL: begin
                o_result.led_mode    = LED_ON;
                o_result.servo_angle = ANGLE_PUSH;
            end
            ST_CLEAR: begin
                o_result.motor_on = 1'b1;
            end
            ST_EMERGENCY: begin
                o_result.led_mode = LED_FAST;
            end
            default: begin
                o_result.led_mode = LED_SLOW;
            end
        endcase
    end

endmodule

// File: src/conveyor_interlock_controller_core.sv
// ---------------------------------------------------------------------------
// conveyor_interlock_controller_core : conveyor interlock controller
// Two-hand guard interlock, emergency stop, metal ejection and box counting.
//
//   channel  | dir | handshake             | payload
//   ---------+-----+-----------------------+---------------------------------
//   s_axis   | in  | tvalid / tready       | tdata: gates, guards, buttons;
//            |     |                       | tuser: mode (0 sample, 1 tick)
//   m_axis   | out | tvalid / tready       | tdata: state, led, motor,
//            |     |                       | servo angle, count
//   cfg      | in  | i_cfg_we              | i_cfg_idx, i_cfg_wdata
//
// One beat per cycle sustained while the output is not stalled; each beat gives one
// result, registered in the input register, then in the result register.
// Reset: state idle, count and timer zero, hold registers 1000 and 1500.
// A stalled output holds the result register; the input register keeps
// taking a beat while it is empty or while the result stage moves.
// ---------------------------------------------------------------------------
module conveyor_interlock_controller_core import cic_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [7:0]           s_axis_tdata,  // gate_start, gate_end, guard_left,
                                                // guard_right, metal_sensed,
                                                // emergency_pressed, reset_pressed, 0
    input  logic                 s_axis_tuser,  // mode
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [23:0]          m_axis_tdata,  // state_code[3:0], led_mode[5:4],
                                                // motor_on[6], servo_angle[14:7],
                                                // count_now[22:15], 0
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_wdata
);

    logic [TIMER_W-1:0] r_metal_ticks;
    logic [TIMER_W-1:0] r_clear_ticks;
    t_ctrl_regs         r_ctrl;
    t_ctrl_regs         n_ctrl;
    t_result            r_result;
    t_result            n_result;
    logic               r_out_valid;
    logic               w_out_free;
    logic               w_in_valid;
    logic               w_advance;
    t_item              w_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_metal_ticks <= METAL_HOLD_RST;
            r_clear_ticks <= CLEAR_HOLD_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_METAL_HOLD: r_metal_ticks <= i_cfg_wdata;
                CFG_CLEAR_HOLD: r_clear_ticks <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    assign w_out_free = !r_out_valid || m_axis_tready;
    assign w_advance  = w_in_valid && w_out_free;

    cic_in_stage u_in_stage (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .i_out_free    (w_out_free),
        .o_valid       (w_in_valid),
        .o_item        (w_item)
    );

    cic_step u_step (
        .i_item       (w_item),
        .i_regs       (r_ctrl),
        .i_metal_hold (r_metal_ticks),
        .i_clear_hold (r_clear_ticks),
        .o_regs       (n_ctrl),
        .o_result     (n_result)
    );

    // advance controller state only when the beat moves into the result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctrl.state           <= ST_IDLE;
            r_ctrl.boxes           <= '0;
            r_ctrl.last_gate_start <= 1'b0;
            r_ctrl.last_gate_end   <= 1'b0;
            r_ctrl.hold_timer      <= '0;
            r_out_valid            <= 1'b0;
        end else begin
            if (w_advance) begin
                r_ctrl <= n_ctrl;
            end
            if (w_out_free) begin
                r_out_valid <= w_in_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_result <= n_result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {1'b0,
                            r_result.count_now,
                            r_result.servo_angle,
                            r_result.motor_on,
                            r_result.led_mode,
                            r_result.state_code};

endmodule
